// ===== src/uce_pkg.sv =====
// Shared types, mode codes and a helper function for the UCS-2 character encoder.
package uce_pkg;

	typedef enum logic [1:0] {
		MODE_UCS2  = 2'd0,
		MODE_UTF8  = 2'd1,
		MODE_ASCII = 2'd2,
		MODE_HTML  = 2'd3
	} mode_t;

	localparam mode_t MODE_RESET = MODE_UTF8;

	localparam int unsigned MaxBytes = 8;
	localparam int unsigned IdxW     = $clog2(MaxBytes);

	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_SEMI  = 8'h3b;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QMARK = 8'h3f;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [15:0] CODE_NBSP = 16'h00a0;

	// One encoded run: byte 0 goes out first, last_idx marks the final byte.
	typedef struct packed {
		logic [MaxBytes-1:0][7:0] bytes;
		logic [IdxW-1:0]          last_idx;
	} run_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] r;
		if (nib < 4'd10) begin
			r = CH_ZERO + {4'd0, nib};
		end else begin
			r = CH_LOW_A + {4'd0, nib - 4'd10};
		end
		return r;
	endfunction

endpackage

// ===== src/uce_encode.sv =====
// Combinational encoder: one code unit and the mode in, one byte run out.
module uce_encode import uce_pkg::*; (
	input  logic [15:0] character,
	input  mode_t       mode,
	output run_t        run
);

	always_comb begin
		run = '0;
		case (mode)
			MODE_UCS2: begin
				run.bytes[0] = character[15:8];
				run.bytes[1] = character[7:0];
				run.last_idx = IdxW'(1);
			end
			MODE_UTF8: begin
				if (character < 16'h0080) begin
					run.bytes[0] = character[7:0];
					run.last_idx = IdxW'(0);
				end else if (character < 16'h0800) begin
					run.bytes[0] = {3'b110, character[10:6]};
					run.bytes[1] = {2'b10, character[5:0]};
					run.last_idx = IdxW'(1);
				end else begin
					run.bytes[0] = {4'b1110, character[15:12]};
					run.bytes[1] = {2'b10, character[11:6]};
					run.bytes[2] = {2'b10, character[5:0]};
					run.last_idx = IdxW'(2);
				end
			end
			MODE_ASCII: begin
				if (character == CODE_NBSP) begin
					run.bytes[0] = CH_SPACE;
				end else if (character >= 16'h0080) begin
					run.bytes[0] = CH_QMARK;
				end else begin
					run.bytes[0] = character[7:0];
				end
				run.last_idx = IdxW'(0);
			end
			MODE_HTML: begin
				if (character < 16'h0080) begin
					run.bytes[0] = character[7:0];
					run.last_idx = IdxW'(0);
				end else begin
					run.bytes[0] = CH_AMP;
					run.bytes[1] = CH_HASH;
					run.bytes[2] = CH_X;
					// hex digits without leading zeros; at least two here
					if (character >= 16'h1000) begin
						run.bytes[3] = hex_char(character[15:12]);
						run.bytes[4] = hex_char(character[11:8]);
						run.bytes[5] = hex_char(character[7:4]);
						run.bytes[6] = hex_char(character[3:0]);
						run.bytes[7] = CH_SEMI;
						run.last_idx = IdxW'(7);
					end else if (character >= 16'h0100) begin
						run.bytes[3] = hex_char(character[11:8]);
						run.bytes[4] = hex_char(character[7:4]);
						run.bytes[5] = hex_char(character[3:0]);
						run.bytes[6] = CH_SEMI;
						run.last_idx = IdxW'(6);
					end else begin
						run.bytes[3] = hex_char(character[7:4]);
						run.bytes[4] = hex_char(character[3:0]);
						run.bytes[5] = CH_SEMI;
						run.last_idx = IdxW'(5);
					end
				end
			end
			default: begin
				run = '0;
			end
		endcase
	end

endmodule

// ===== src/uce_serializer.sv =====
// Run register and byte serializer for the output channel.
module uce_serializer import uce_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load_valid,
	input  run_t       load_run,
	output logic       load_ready,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       last_byte
);

	run_t            run_q;
	logic            busy_q;
	logic [IdxW-1:0] idx_q;
	logic            at_last;
	logic            out_xfer;
	logic            load;

	assign at_last    = (idx_q == run_q.last_idx);
	assign out_xfer   = busy_q && !out_stall;
	// a new run may replace the current one as its final byte transfers
	assign load_ready = !busy_q || (out_xfer && at_last);
	assign load       = load_valid && load_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (out_xfer) begin
				if (at_last) begin
					busy_q <= 1'b0;
					idx_q  <= '0;
				end else begin
					idx_q <= idx_q + IdxW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			run_q <= load_run;
		end
	end

	assign out_valid = busy_q;
	assign out_byte  = run_q.bytes[idx_q];
	assign last_byte = at_last;

endmodule

// ===== src/ucs2_char_encoder_core.sv =====
// Top level of the UCS-2 character encoder: mode register, input stage, encoder, serializer.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------
//  input    | in_valid / in_stall  | character[15:0]
//  output   | out_valid / out_stall| out_byte[7:0], last_byte
//  config   | cfg_wr_en            | cfg_wr_data[1:0] (encoding mode)
//
// A character is held in the input register, then its encoded run is loaded into
// the serializer, which sends one byte per cycle while out_stall is low. A run has
// 1 to 8 bytes, so single-byte runs flow at one character per cycle while out_stall
// is low. in_stall rises while the input register holds a character
// and the serializer cannot take it: bytes of the previous run remain beyond the
// current one, or the current final byte is held by out_stall.
// Reset empties both stages and sets the mode to UTF-8.
module ucs2_char_encoder_core import uce_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] character,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        last_byte
);

	mode_t       mode_q;
	logic        valid_s1;
	logic [15:0] char_s1;
	run_t        enc_run;
	logic        ser_ready;
	logic        in_xfer;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RESET;
		end else if (cfg_wr_en) begin
			mode_q <= mode_t'(cfg_wr_data);
		end
	end

	assign in_stall = valid_s1 && !ser_ready;
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			char_s1 <= character;
		end
	end

	uce_encode u_encode (
		.character (char_s1),
		.mode      (mode_q),
		.run       (enc_run)
	);

	uce_serializer u_serializer (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (valid_s1),
		.load_run   (enc_run),
		.load_ready (ser_ready),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.last_byte  (last_byte)
	);

endmodule
